FILE: hdl/itda_pkg.sv
// Package for the integer to decimal ASCII formatter.
// Holds widths, character codes, the controller state type and the
// command/status structs shared by the controller and datapath.
package itda_pkg;

  localparam int VALUE_W       = 32;
  localparam int CHAR_W        = 8;
  localparam int MAX_DIGITS    = 10;
  localparam int BCD_W         = 4 * MAX_DIGITS;
  localparam int DIG_IDX_W     = $clog2(MAX_DIGITS);
  localparam int BITS_PER_STEP = 4;
  localparam int STEP_CNT      = VALUE_W / BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(STEP_CNT);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_LEAD,
    ST_SIGN,
    ST_DIGITS
  } itda_state_t;

  typedef struct packed {
    logic load;      // capture the request and form the magnitude
    logic step;      // one double-dabble step of BITS_PER_STEP bits
    logic lead;      // locate the leading nonzero digit
    logic next_dig;  // move to the next lower digit
    logic sel_sign;  // present '-' instead of a digit
  } itda_cmd_t;

  typedef struct packed {
    logic conv_done;  // last conversion step is in progress
    logic neg;        // value was signed and negative
    logic dig_zero;   // current digit is the least significant one
  } itda_sts_t;

endpackage

FILE: hdl/itda_if.sv
// Valid/ready channel interfaces for the formatter.
// Depends on itda_pkg for the payload widths.
interface itda_in_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [itda_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface itda_out_if;
  logic                           valid;
  logic                           ready;
  logic [itda_pkg::CHAR_W-1:0]    char_code;
  logic                           last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

FILE: hdl/integer_to_decimal_ascii.sv
// Integer to decimal ASCII formatter. Each request carries a 32-bit value
// and a flag (req_type: 0 unsigned, 1 two's complement); the block returns
// the decimal text one character per result, most significant digit first,
// leading zeros dropped, a '-' in front of negative signed values, and
// last_char set on the final character. One request is handled at a time:
// the request is taken, the binary-to-BCD conversion runs 4 bits per cycle
// until all 32 bits are shifted in, the leading digit is found, then the
// characters are presented one at a time, each held until out_ready takes it.
// Depends on itda_pkg, itda_if, itda_ctrl and itda_datapath.
module integer_to_decimal_ascii (
  input  logic              clk,
  input  logic              rst_n,
  itda_in_if.sink           in_req,
  itda_out_if.source        out_rsp
);
  import itda_pkg::*;

  itda_cmd_t cmd;
  itda_sts_t sts;

  itda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  itda_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .req_type  (in_req.req_type),
    .value     (in_req.value),
    .sts       (sts),
    .char_code (out_rsp.char_code),
    .last_char (out_rsp.last_char)
  );

endmodule

FILE: hdl/itda_datapath.sv
// Datapath of the formatter: magnitude register, BCD register built by
// double dabble, digit pointer and character selection. Uses itda_pkg.
module itda_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  itda_pkg::itda_cmd_t          cmd,
  input  logic                         req_type,
  input  logic [itda_pkg::VALUE_W-1:0] value,
  output itda_pkg::itda_sts_t          sts,
  output logic [itda_pkg::CHAR_W-1:0]  char_code,
  output logic                         last_char
);
  import itda_pkg::*;

  logic [VALUE_W-1:0]    bin_r, bin_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIG_IDX_W-1:0]  idx_r, idx_nxt;
  logic                  neg_r, neg_nxt;

  logic [VALUE_W-1:0]    bin_step;
  logic [BCD_W-1:0]      bcd_step;
  logic [DIG_IDX_W-1:0]  lead_idx;
  logic [3:0]            cur_dig;
  logic                  is_neg;

  assign is_neg = req_type & value[VALUE_W-1];

  // BITS_PER_STEP shift-and-add-3 iterations per cycle
  always_comb begin
    bin_step = bin_r;
    bcd_step = bcd_r;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (bcd_step[4*d +: 4] >= 4'd5) begin
          bcd_step[4*d +: 4] = bcd_step[4*d +: 4] + 4'd3;
        end
      end
      bcd_step = {bcd_step[BCD_W-2:0], bin_step[VALUE_W-1]};
      bin_step = {bin_step[VALUE_W-2:0], 1'b0};
    end
  end

  // highest nonzero digit; zero value leaves the pointer at digit 0
  always_comb begin
    lead_idx = '0;
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] != 4'd0) begin
        lead_idx = DIG_IDX_W'(d);
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    neg_nxt = neg_r;
    if (cmd.load) begin
      bin_nxt = is_neg ? (VALUE_W'(0) - value) : value;
      neg_nxt = is_neg;
      bcd_nxt = '0;
      cnt_nxt = '0;
    end
    if (cmd.step) begin
      bin_nxt = bin_step;
      bcd_nxt = bcd_step;
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.lead) begin
      idx_nxt = lead_idx;
    end
    if (cmd.next_dig) begin
      idx_nxt = idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
      neg_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      neg_r <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign cur_dig   = bcd_r[{idx_r, 2'b00} +: 4];
  assign char_code = cmd.sel_sign ? ASCII_MINUS : (ASCII_ZERO + {4'b0000, cur_dig});
  assign last_char = ~cmd.sel_sign & (idx_r == '0);

  assign sts.conv_done = (cnt_r == STEP_CNT_W'(STEP_CNT - 1));
  assign sts.neg       = neg_r;
  assign sts.dig_zero  = (idx_r == '0);

endmodule

FILE: hdl/itda_ctrl.sv
// Controller of the formatter: state machine that sequences load,
// conversion, leading-digit search and character output. Uses itda_pkg.
module itda_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  itda_pkg::itda_sts_t sts,
  output itda_pkg::itda_cmd_t cmd
);
  import itda_pkg::*;

  itda_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (sts.conv_done) begin
          state_nxt = ST_LEAD;
        end
      end
      ST_LEAD: begin
        cmd.lead  = 1'b1;
        state_nxt = sts.neg ? ST_SIGN : ST_DIGITS;
      end
      ST_SIGN: begin
        cmd.sel_sign = 1'b1;
        out_valid    = 1'b1;
        if (out_ready) begin
          state_nxt = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.dig_zero) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.next_dig = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
